[src/wcm_pkg.sv]
// ----------------------------------------------------------------------------
// wcm_pkg: shared types and constants of the wall column texture mapper
// field widths, register map, queue item and configuration group
// ----------------------------------------------------------------------------
`default_nettype none

package wcm_pkg;

   // item field widths
   localparam int COLUMN_W  = 12;
   localparam int FACE_W    = 2;
   localparam int HIT_W     = 16;
   localparam int ROWF_W    = 12;
   localparam int ROWE_W    = 13;
   localparam int HEIGHT_W  = 16;
   localparam int DEST_W    = 24;
   localparam int TEXEL_W   = 20;

   // register widths
   localparam int L2_W      = 4;
   localparam int SCR_W     = 13;

   // internal arithmetic
   localparam int POS_W     = 48;
   localparam int OFS_W     = 20;
   localparam int DIFF_W    = 18;

   // parameter defaults
   localparam int DEF_MAX_SCREEN_DIM = 4096;
   localparam int DEF_MAX_TEX_LOG2   = 10;
   localparam int DEF_FRAC_BITS      = 16;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TEX_NORTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_SOUTH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_EAST      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WEST      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_PITCH    = 3'd6;

   localparam logic [L2_W-1:0]  RST_TEX_LOG2      = 4'd6;
   localparam logic [SCR_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
   localparam logic [SCR_W-1:0] RST_SCREEN_HEIGHT = 13'd480;
   localparam logic [SCR_W-1:0] RST_VIEW_PITCH    = 13'd0;

   // opcodes and faces
   localparam logic OP_START = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   localparam logic [FACE_W-1:0] FACE_NORTH = 2'd0;
   localparam logic [FACE_W-1:0] FACE_SOUTH = 2'd1;
   localparam logic [FACE_W-1:0] FACE_EAST  = 2'd2;
   localparam logic [FACE_W-1:0] FACE_WEST  = 2'd3;

   typedef struct packed {
      logic [3:0][L2_W-1:0] tex_log2;
      logic [SCR_W-1:0]     screen_width;
      logic [SCR_W-1:0]     screen_height;
      logic signed [SCR_W-1:0] view_pitch;
   } wcm_cfg_type;

   // classified item as it waits in the queue
   typedef struct packed {
      logic                    is_start;
      logic [COLUMN_W-1:0]     column;
      logic [FACE_W-1:0]       face;
      logic [L2_W-1:0]         log2;
      logic                    mirror;
      logic [HIT_W-1:0]        hit_fraction;
      logic [ROWF_W-1:0]       row_first;
      logic [ROWE_W-1:0]       row_end;
      logic [HEIGHT_W-1:0]     height;
      logic signed [OFS_W-1:0] offset;
   } wcm_item_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_MULTIPLY
   } wcm_back_state_type;

   // log2 of texture size held inside 1 .. max_l
   function automatic logic [L2_W-1:0] clamp_log2(input logic [L2_W-1:0] l,
                                                   input logic [L2_W-1:0] max_l);
      logic [L2_W-1:0] r;
      r = l;
      if (r < L2_W'(1)) r = L2_W'(1);
      if (r > max_l) r = max_l;
      return r;
   endfunction

endpackage

`default_nettype wire

[src/wcm_channels_if.sv]
// ----------------------------------------------------------------------------
// wcm channels: request and response handshake interfaces
// valid/ready channels carrying the item and result fields
// ----------------------------------------------------------------------------
`default_nettype none

interface wcm_req_if import wcm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [COLUMN_W-1:0]   column;
   logic [FACE_W-1:0]     face;
   logic [HIT_W-1:0]      hit_fraction;
   logic                  ray_x_positive;
   logic                  ray_y_negative;
   logic [ROWF_W-1:0]     row_first;
   logic [ROWE_W-1:0]     row_end;
   logic [HEIGHT_W-1:0]   wall_height;

   modport source (
      output valid, opcode, column, face, hit_fraction, ray_x_positive,
             ray_y_negative, row_first, row_end, wall_height,
      input  ready
   );
   modport sink (
      input  valid, opcode, column, face, hit_fraction, ray_x_positive,
             ray_y_negative, row_first, row_end, wall_height,
      output ready
   );
endinterface

interface wcm_rsp_if import wcm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [DEST_W-1:0]     dest_index;
   logic [FACE_W-1:0]     texture_face;
   logic [TEXEL_W-1:0]    texel_index;
   logic                  last_pixel;

   modport source (
      output valid, dest_index, texture_face, texel_index, last_pixel,
      input  ready
   );
   modport sink (
      input  valid, dest_index, texture_face, texel_index, last_pixel,
      output ready
   );
endinterface

`default_nettype wire

[src/wcm_queue.sv]
// ----------------------------------------------------------------------------
// wcm_queue: short item queue between front and back
// register-based fifo of classified items
// ----------------------------------------------------------------------------
`default_nettype none

module wcm_queue import wcm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   input  wcm_item_type      push_data,
   output logic              push_ready,
   output logic              pop_valid,
   output wcm_item_type      pop_data,
   input  wire logic         pop_ready
);

   wcm_item_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push_fire;
   logic              pop_fire;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[src/wcm_front.sv]
// ----------------------------------------------------------------------------
// wcm_front: request acceptance and classification
// clamps texture size, picks mirroring, fixes zero height, centers the start
// ----------------------------------------------------------------------------
`default_nettype none

module wcm_front import wcm_pkg::*; #(
   parameter int MAX_TEX_LOG2 = DEF_MAX_TEX_LOG2
) (
   wcm_req_if.sink           req,
   input  wcm_cfg_type       cfg,
   output logic              push_valid,
   output wcm_item_type      push_data,
   input  wire logic         push_ready
);

   logic                     ew_face;
   logic [HEIGHT_W-1:0]      height;
   logic signed [DIFF_W-1:0] diff;
   logic signed [DIFF_W-1:0] half;
   logic signed [OFS_W-1:0]  row_s;

   assign push_valid = req.valid;
   assign req.ready  = push_ready;

   always_comb begin
      ew_face = (req.face == FACE_EAST) || (req.face == FACE_WEST);
      height  = (req.wall_height == '0) ? HEIGHT_W'(1) : req.wall_height;

      // (screen_height - h) / 2, truncated toward zero
      diff  = $signed({{(DIFF_W - SCR_W){1'b0}}, cfg.screen_height})
            - $signed({{(DIFF_W - HEIGHT_W){1'b0}}, height});
      half  = (diff + $signed({{(DIFF_W - 1){1'b0}}, diff[DIFF_W-1]})) >>> 1;
      row_s = $signed({{(OFS_W - ROWF_W){1'b0}}, req.row_first});

      push_data.is_start     = (req.opcode == OP_START);
      push_data.column       = req.column;
      push_data.face         = req.face;
      push_data.log2         = clamp_log2(cfg.tex_log2[req.face], L2_W'(MAX_TEX_LOG2));
      push_data.mirror       = ew_face ? req.ray_x_positive : req.ray_y_negative;
      push_data.hit_fraction = req.hit_fraction;
      push_data.row_first    = req.row_first;
      push_data.row_end      = req.row_end;
      push_data.height       = height;
      push_data.offset       = row_s - OFS_W'(cfg.view_pitch) - OFS_W'(half);
   end

endmodule

`default_nettype wire

[src/wcm_divider.sv]
// ----------------------------------------------------------------------------
// wcm_divider: restoring divider, one quotient bit per cycle
// used for the vertical texture step
// ----------------------------------------------------------------------------
`default_nettype none

module wcm_divider #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numerator,
   input  wire logic [DEN_W-1:0] denominator,
   output logic                  done,
   output logic [NUM_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;
   logic             fits;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      shifted  = {rem_ff, quo_ff[NUM_W-1]};
      fits     = (shifted >= {1'b0, den_ff});
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = numerator;
         rem_in   = '0;
         den_in   = denominator;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[NUM_W-2:0], fits};
         rem_in   = fits ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

`default_nettype wire

[src/wcm_back.sv]
// ----------------------------------------------------------------------------
// wcm_back: column execution
// loads a column (step divide, start position multiply), emits pixel results
// ----------------------------------------------------------------------------
`default_nettype none

module wcm_back import wcm_pkg::*; #(
   parameter int MAX_SCREEN_DIM = DEF_MAX_SCREEN_DIM,
   parameter int MAX_TEX_LOG2   = DEF_MAX_TEX_LOG2,
   parameter int FRAC_BITS      = DEF_FRAC_BITS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wcm_cfg_type       cfg,
   input  wire logic         pop_valid,
   input  wcm_item_type      pop_data,
   output logic              pop_ready,
   wcm_rsp_if.source         rsp
);

   localparam int TL_W    = MAX_TEX_LOG2;
   localparam int NUM_W   = TL_W + FRAC_BITS + 1;
   localparam int ROW_W   = $clog2(MAX_SCREEN_DIM) + 1;
   localparam int PROD_W  = OFS_W + NUM_W + 1;
   localparam int DPROD_W = ROW_W + SCR_W;

   wcm_back_state_type      state_ff, state_in;
   logic                    column_active_ff, column_active_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [NUM_W-1:0]        step_ff, step_in;
   logic signed [OFS_W-1:0] offset_ff, offset_in;
   logic [ROW_W-1:0]        cur_ff, cur_in;
   logic [ROW_W-1:0]        stop_ff, stop_in;
   logic [TL_W-1:0]         tc_ff, tc_in;
   logic [FACE_W-1:0]       face_ff, face_in;
   logic [COLUMN_W-1:0]     col_ff, col_in;
   logic [DEST_W-1:0]       rsp_dest_ff, rsp_dest_in;
   logic [TEXEL_W-1:0]      rsp_texel_ff, rsp_texel_in;
   logic [FACE_W-1:0]       rsp_face_ff, rsp_face_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    out_free;
   logic                    pop_fire;
   logic                    pixel_emit;
   logic                    div_start;
   logic                    div_done;
   logic [NUM_W-1:0]        div_quotient;
   logic [NUM_W-1:0]        div_numerator;

   // start side
   logic [L2_W-1:0]         l_start;
   logic [TL_W-1:0]         mask_start;
   logic [TL_W-1:0]         tx_raw;
   logic [ROW_W-1:0]        first_row;
   logic [ROW_W-1:0]        end_row;

   // pixel side
   logic [L2_W-1:0]         l_pix;
   logic [TL_W-1:0]         mask_pix;
   logic [TL_W-1:0]         row_raw;
   logic [2*TL_W-1:0]       texel_wide;
   logic [DPROD_W-1:0]      dest_wide;
   logic                    pix_last;
   logic signed [PROD_W-1:0] prod;

   wcm_divider #(
      .NUM_W (NUM_W),
      .DEN_W (HEIGHT_W)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_numerator),
      .denominator (pop_data.height),
      .done        (div_done),
      .quotient    (div_quotient)
   );

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.dest_index   = rsp_dest_ff;
   assign rsp.texel_index  = rsp_texel_ff;
   assign rsp.texture_face = rsp_face_ff;
   assign rsp.last_pixel   = rsp_last_ff;

   always_comb begin
      // start datapath
      l_start       = pop_data.log2;
      mask_start    = ~({TL_W{1'b1}} << l_start);
      tx_raw        = TL_W'(pop_data.hit_fraction >> (5'(HIT_W) - {1'b0, l_start}));
      first_row     = ROW_W'(pop_data.row_first);
      end_row       = ROW_W'(pop_data.row_end);
      div_numerator = NUM_W'(1) << (l_start + FRAC_BITS);

      // pixel datapath, texel row truncated toward zero
      l_pix      = clamp_log2(cfg.tex_log2[face_ff], L2_W'(MAX_TEX_LOG2));
      mask_pix   = ~({TL_W{1'b1}} << l_pix);
      row_raw    = pos_ff[FRAC_BITS +: TL_W]
                 + TL_W'(pos_ff[POS_W-1] && (pos_ff[FRAC_BITS-1:0] != '0));
      // the latched texel column may exceed a size shrunk mid column, so add
      texel_wide = ({{TL_W{1'b0}}, row_raw & mask_pix} << l_pix) + {{TL_W{1'b0}}, tc_ff};
      dest_wide  = cur_ff * cfg.screen_width + DPROD_W'(col_ff);
      pix_last   = ({1'b0, cur_ff} + 1'b1) >= {1'b0, stop_ff};

      prod = offset_ff * $signed({1'b0, step_ff});

      out_free = !rsp_valid_ff || rsp.ready;

      state_in         = state_ff;
      column_active_in = column_active_ff;
      pos_in           = pos_ff;
      step_in          = step_ff;
      offset_in        = offset_ff;
      cur_in           = cur_ff;
      stop_in          = stop_ff;
      tc_in            = tc_ff;
      face_in          = face_ff;
      col_in           = col_ff;
      rsp_dest_in      = rsp_dest_ff;
      rsp_texel_in     = rsp_texel_ff;
      rsp_face_in      = rsp_face_ff;
      rsp_last_in      = rsp_last_ff;
      pop_ready        = 1'b0;
      pixel_emit       = 1'b0;
      div_start        = 1'b0;

      case (state_ff)
         BACK_IDLE: begin
            pop_ready = pop_data.is_start || !column_active_ff || out_free;
            if (pop_valid && pop_ready) begin
               if (pop_data.is_start) begin
                  tc_in            = pop_data.mirror ? (~tx_raw & mask_start) : tx_raw;
                  face_in          = pop_data.face;
                  col_in           = pop_data.column;
                  cur_in           = first_row;
                  stop_in          = end_row;
                  offset_in        = pop_data.offset;
                  column_active_in = (first_row < end_row);
                  div_start        = 1'b1;
                  state_in         = BACK_DIVIDE;
               end else if (column_active_ff) begin
                  pixel_emit   = 1'b1;
                  rsp_dest_in  = DEST_W'(dest_wide);
                  rsp_texel_in = TEXEL_W'(texel_wide);
                  rsp_face_in  = face_ff;
                  rsp_last_in  = pix_last;
                  pos_in       = pos_ff + POS_W'(step_ff);
                  cur_in       = cur_ff + 1'b1;
                  if (pix_last) begin
                     column_active_in = 1'b0;
                  end
               end
            end
         end
         BACK_DIVIDE: begin
            if (div_done) begin
               step_in  = div_quotient;
               state_in = BACK_MULTIPLY;
            end
         end
         BACK_MULTIPLY: begin
            pos_in   = POS_W'(prod);
            state_in = BACK_IDLE;
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase

      if (pixel_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign pop_fire = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= BACK_IDLE;
         column_active_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         column_active_ff <= column_active_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      step_ff      <= step_in;
      offset_ff    <= offset_in;
      cur_ff       <= cur_in;
      stop_ff      <= stop_in;
      tc_ff        <= tc_in;
      face_ff      <= face_in;
      col_ff       <= col_in;
      rsp_dest_ff  <= rsp_dest_in;
      rsp_texel_ff <= rsp_texel_in;
      rsp_face_ff  <= rsp_face_in;
      rsp_last_ff  <= rsp_last_in;
   end

   a_no_pop_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != BACK_IDLE) |-> !pop_fire)
      else $error("queue popped while a column load is in progress");

   a_active_span: assert property (@(posedge clock) disable iff (reset)
      column_active_ff |-> (cur_ff < stop_ff))
      else $error("active column with no rows left");

   a_divide_then_multiply: assert property (@(posedge clock) disable iff (reset)
      div_done |=> (state_ff == BACK_MULTIPLY))
      else $error("divider finished without start position multiply");

   a_last_closes_column: assert property (@(posedge clock) disable iff (reset)
      (pixel_emit && pix_last) |=> !column_active_ff)
      else $error("column still active after its last pixel");

endmodule

`default_nettype wire

[src/wall_column_texture_mapper.sv]
// ----------------------------------------------------------------------------
// wall_column_texture_mapper: textured wall column coordinate generator
// start transactions load a column, pixel transactions return one screen
// pixel index and one texel index each
// ----------------------------------------------------------------------------
// A start transaction (opcode 0) loads a column and returns nothing; each pixel
// transaction (opcode 1) returns one result while the column is active and
// nothing otherwise. Requests go through a two-entry queue, so the request side
// keeps taking transactions while the back end works. In the back end a pixel
// transaction for an active column is taken once the result register is free
// to hold its result, but not while a column loads; a start transaction loads
// the column, runs the restoring divider that forms the texture step, takes the
// quotient, and then does the multiply that forms the start position.
// Configuration registers sit behind an APB-style port at byte address
// 4*index and are read live by the pixel path (texture size, width).
// ----------------------------------------------------------------------------
`default_nettype none

module wall_column_texture_mapper import wcm_pkg::*; #(
   parameter int MAX_SCREEN_DIM = DEF_MAX_SCREEN_DIM,
   parameter int MAX_TEX_LOG2   = DEF_MAX_TEX_LOG2,
   parameter int FRAC_BITS      = DEF_FRAC_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   wcm_req_if.sink                    req_bus,
   wcm_rsp_if.source                  rsp_bus,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   // configuration registers
   logic [3:0][L2_W-1:0] tex_log2_ff, tex_log2_in;
   logic [SCR_W-1:0]     screen_width_ff, screen_width_in;
   logic [SCR_W-1:0]     screen_height_ff, screen_height_in;
   logic [SCR_W-1:0]     view_pitch_ff, view_pitch_in;

   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   wcm_cfg_type          cfg;

   // front to queue, queue to back
   logic                 push_valid;
   logic                 push_ready;
   wcm_item_type         push_data;
   logic                 pop_valid;
   logic                 pop_ready;
   wcm_item_type         pop_data;

   // no wait states, write lands on the access phase
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      tex_log2_in      = tex_log2_ff;
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      view_pitch_in    = view_pitch_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_TEX_NORTH:     tex_log2_in[FACE_NORTH] = pwdata[L2_W-1:0];
            CSR_TEX_SOUTH:     tex_log2_in[FACE_SOUTH] = pwdata[L2_W-1:0];
            CSR_TEX_EAST:      tex_log2_in[FACE_EAST]  = pwdata[L2_W-1:0];
            CSR_TEX_WEST:      tex_log2_in[FACE_WEST]  = pwdata[L2_W-1:0];
            CSR_SCREEN_WIDTH:  screen_width_in  = pwdata[SCR_W-1:0];
            CSR_SCREEN_HEIGHT: screen_height_in = pwdata[SCR_W-1:0];
            CSR_VIEW_PITCH:    view_pitch_in    = pwdata[SCR_W-1:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // register readback, zero extended
   always_comb begin
      case (csr_index)
         CSR_TEX_NORTH:     prdata = CSR_DATA_W'(tex_log2_ff[FACE_NORTH]);
         CSR_TEX_SOUTH:     prdata = CSR_DATA_W'(tex_log2_ff[FACE_SOUTH]);
         CSR_TEX_EAST:      prdata = CSR_DATA_W'(tex_log2_ff[FACE_EAST]);
         CSR_TEX_WEST:      prdata = CSR_DATA_W'(tex_log2_ff[FACE_WEST]);
         CSR_SCREEN_WIDTH:  prdata = CSR_DATA_W'(screen_width_ff);
         CSR_SCREEN_HEIGHT: prdata = CSR_DATA_W'(screen_height_ff);
         CSR_VIEW_PITCH:    prdata = CSR_DATA_W'(view_pitch_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_log2_ff      <= {4{RST_TEX_LOG2}};
         screen_width_ff  <= RST_SCREEN_WIDTH;
         screen_height_ff <= RST_SCREEN_HEIGHT;
         view_pitch_ff    <= RST_VIEW_PITCH;
      end else begin
         tex_log2_ff      <= tex_log2_in;
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         view_pitch_ff    <= view_pitch_in;
      end
   end

   // configuration group shared by front and back
   always_comb begin
      cfg.tex_log2      = tex_log2_ff;
      cfg.screen_width  = screen_width_ff;
      cfg.screen_height = screen_height_ff;
      cfg.view_pitch    = $signed(view_pitch_ff);
   end

   // front: takes request transactions and classifies them
   wcm_front #(
      .MAX_TEX_LOG2 (MAX_TEX_LOG2)
   ) u_front (
      .req        (req_bus),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   // queue decouples request acceptance from column execution
   wcm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   // back: column load and pixel generation, owns the result register
   wcm_back #(
      .MAX_SCREEN_DIM (MAX_SCREEN_DIM),
      .MAX_TEX_LOG2   (MAX_TEX_LOG2),
      .FRAC_BITS      (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp       (rsp_bus)
   );

endmodule

`default_nettype wire
